FILE: design/wbps_pkg.sv
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// Depends on nothing; every other file but wbps_req_if refers to it by scope.
package wbps_pkg;

   localparam int SIG_MAX  = 16;                 // longest signature in bytes
   localparam int SIG_BITS = SIG_MAX * 8;
   localparam int IDX_W    = $clog2(SIG_MAX);    // selects one signature byte
   localparam int LEN_W    = 5;                  // signature_length register
   localparam int WORD_W   = 32;
   localparam int CSR_W    = 64;

   typedef enum logic [2:0] {
      CSR_SIG_LOW    = 3'd0,
      CSR_SIG_HIGH   = 3'd1,
      CSR_WILD_MASK  = 3'd2,
      CSR_SIG_LENGTH = 3'd3,
      CSR_MATCH_IDX  = 3'd4,
      CSR_BASE_ADDR  = 3'd5,
      CSR_ADDR_OFS   = 3'd6
   } csr_addr_type;

   // one result as it leaves the block
   typedef struct packed {
      logic [WORD_W-1:0] match_start;
      logic [WORD_W-1:0] match_number;
      logic              is_selected;
      logic [WORD_W-1:0] match_address;
      logic              done_res;
      logic              found;
   } rsp_type;

   // what one window cell compares its byte against
   typedef struct packed {
      logic [7:0] pat_byte;
      logic       care;
   } pat_type;

   // window movement for every cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // result queue status towards the scan stage
   typedef struct packed {
      logic can_push;
      logic not_empty;
   } obuf_stat_type;

   function automatic logic [7:0] sig_byte(input logic [SIG_BITS-1:0] sig,
                                           input logic [IDX_W-1:0]    idx);
      sig_byte = sig[idx*8 +: 8];
   endfunction

endpackage

FILE: design/wbps_req_if.sv
// Request channel of the scanner: one buffer byte per request.
// Depends on nothing.
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: design/wbps_rsp_if.sv
// Result channel of the scanner: match items and the end-of-buffer item.
// Depends on wbps_pkg for the word width.
interface wbps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wbps_pkg::WORD_W-1:0]  match_start;
   logic [wbps_pkg::WORD_W-1:0]  match_number;
   logic                         is_selected;
   logic [wbps_pkg::WORD_W-1:0]  match_address;
   logic                         done_res;
   logic                         found;

   modport source (output valid, output match_start, output match_number,
                   output is_selected, output match_address, output done_res,
                   output found, input ready);
   modport sink   (input valid, input match_start, input match_number,
                   input is_selected, input match_address, input done_res,
                   input found, output ready);
endinterface

FILE: design/wbps_cell.sv
// One window cell: holds a byte, passes it on, and compares the byte it is
// about to take against its pattern byte. Depends on wbps_pkg.
module wbps_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wbps_pkg::cell_ctl_type ctl,
   input  wbps_pkg::pat_type      pat,
   input  logic [7:0]             prev_byte,
   output logic [7:0]             byte_out,
   output logic                   match_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctl.shift) begin
         byte_in = ctl.clear ? 8'h00 : prev_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_in;
      end
   end

   // compare on the shifted-in byte, before any end-of-buffer clear
   assign match_out = !pat.care || (prev_byte == pat.pat_byte);
   assign byte_out  = byte_ff;

endmodule

FILE: design/wbps_obuf.sv
// Two-entry result queue between the scan stage and the result channel.
// Depends on wbps_pkg for the result type.
module wbps_obuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  wbps_pkg::rsp_type       push_data,
   input  logic                    pop,
   output wbps_pkg::rsp_type       head,
   output wbps_pkg::obuf_stat_type stat
);

   wbps_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head           = entry_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != 2'd0);
   // decide on the registered count only, so the request side never waits on rsp ready
   assign stat.can_push  = (count_ff != 2'd2);

endmodule

FILE: design/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: window cells, scan stage,
// result queue and registers. Depends on wbps_pkg, wbps_req_if, wbps_rsp_if,
// wbps_cell and wbps_obuf.
//
//   channel    role    moves                       handshake
//   req_chan   sink    data_byte, last_byte        valid / ready
//   rsp_chan   source  match or end-of-buffer item valid / ready
//   csr_*      write   register index, 64b data    csr_we, no wait
//
// One request is taken per cycle while the result queue has room; a request
// with a match and last_byte set yields two results and holds the scan stage
// until both are queued.
// The window cells compare and shift on the accept edge; the scan stage then
// numbers the match and forms the address; a two-entry queue drives rsp_chan.
// Reset is synchronous and clears the stream state and registers at once.
// A stalled rsp_chan fills the queue, then holds req_chan ready low.
module wildcard_byte_pattern_scanner (
   input  logic                               clock,
   input  logic                               reset,
   wbps_req_if.sink                           req_chan,
   wbps_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [wbps_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int SM = wbps_pkg::SIG_MAX;
   localparam int LW = wbps_pkg::LEN_W;
   localparam int WW = wbps_pkg::WORD_W;

   // registers
   logic [63:0]        sig_low_ff;
   logic [63:0]        sig_high_ff;
   logic [15:0]        wild_ff;
   logic [LW-1:0]      len_ff;
   logic [WW-1:0]      index_ff;
   logic [WW-1:0]      base_ff;
   logic [WW-1:0]      offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_low_ff  <= '0;
         sig_high_ff <= '0;
         wild_ff     <= '0;
         len_ff      <= LW'(1);
         index_ff    <= '0;
         base_ff     <= '0;
         offset_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            wbps_pkg::CSR_SIG_LOW:    sig_low_ff  <= csr_wdata;
            wbps_pkg::CSR_SIG_HIGH:   sig_high_ff <= csr_wdata;
            wbps_pkg::CSR_WILD_MASK:  wild_ff     <= csr_wdata[15:0];
            wbps_pkg::CSR_SIG_LENGTH: len_ff      <= csr_wdata[LW-1:0];
            wbps_pkg::CSR_MATCH_IDX:  index_ff    <= csr_wdata[WW-1:0];
            wbps_pkg::CSR_BASE_ADDR:  base_ff     <= csr_wdata[WW-1:0];
            wbps_pkg::CSR_ADDR_OFS:   offset_ff   <= csr_wdata[WW-1:0];
            default: ;
         endcase
      end
   end

   logic [wbps_pkg::SIG_BITS-1:0] sig_all;
   logic [LW-1:0]                 len_sat;
   logic [LW-1:0]                 len_m1;

   assign sig_all = {sig_high_ff, sig_low_ff};
   assign len_sat = (len_ff > LW'(SM)) ? LW'(SM) : len_ff;
   assign len_m1  = (len_sat == '0) ? '0 : len_sat - LW'(1);

   // handshake between request side and scan stage
   logic                    accept;
   logic                    b_finish;
   logic                    b_vld_ff;

   assign req_chan.ready = !b_vld_ff || b_finish;
   assign accept         = req_chan.valid && req_chan.ready;

   // window cells, cell 0 newest
   wbps_pkg::cell_ctl_type cell_ctl;
   logic [7:0]             cell_byte [SM];
   logic [SM-1:0]          cell_match;

   assign cell_ctl.shift = accept;
   assign cell_ctl.clear = req_chan.last_byte;

   for (genvar k = 0; k < SM; k++) begin : g_cell
      localparam logic [LW-1:0] CELL_POS = LW'(k);
      wbps_pkg::pat_type          pat;
      logic [LW-1:0]              sig_pos;
      logic [7:0]                 prev_byte;

      // newest byte sits at signature position len-1
      assign sig_pos      = len_m1 - CELL_POS;
      assign pat.pat_byte = wbps_pkg::sig_byte(sig_all, sig_pos[wbps_pkg::IDX_W-1:0]);
      assign pat.care     = (CELL_POS < len_sat) && !wild_ff[sig_pos[wbps_pkg::IDX_W-1:0]];

      if (k == 0) begin : g_head
         assign prev_byte = req_chan.data_byte;
      end else begin : g_link
         assign prev_byte = cell_byte[k-1];
      end

      wbps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .pat       (pat),
         .prev_byte (prev_byte),
         .byte_out  (cell_byte[k]),
         .match_out (cell_match[k])
      );
   end

   // fill level and byte position
   logic [LW-1:0] fill_ff, fill_in, fill_inc;
   logic [WW-1:0] pos_ff, pos_in;
   logic          hit_now;

   always_comb begin
      fill_inc = (fill_ff == LW'(SM)) ? fill_ff : fill_ff + LW'(1);
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      if (accept) begin
         fill_in = req_chan.last_byte ? '0 : fill_inc;
         pos_in  = req_chan.last_byte ? '0 : pos_ff + WW'(1);
      end
      hit_now = (fill_inc >= len_sat) && (&cell_match);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pos_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

   // scan stage
   logic          b_hit_ff;
   logic          b_last_ff;
   logic          b_msent_ff, b_msent_in;
   logic [WW-1:0] b_start_ff;
   logic          b_vld_in;
   logic [WW-1:0] count_ff, count_in;
   logic          seen_ff, seen_in;
   logic          match_pend;
   logic          push;
   logic          sel;
   wbps_pkg::rsp_type       push_data;
   wbps_pkg::rsp_type       head;
   wbps_pkg::obuf_stat_type obuf_stat;

   always_comb begin
      match_pend = b_hit_ff && !b_msent_ff;
      push       = b_vld_ff && obuf_stat.can_push && (match_pend || b_last_ff);
      b_finish   = b_vld_ff && (!(match_pend || b_last_ff) ||
                                (obuf_stat.can_push && !(match_pend && b_last_ff)));
      sel        = (count_ff == index_ff);

      push_data = '0;
      if (match_pend) begin
         push_data.match_start   = b_start_ff;
         push_data.match_number  = count_ff;
         push_data.is_selected   = sel;
         push_data.match_address = base_ff + offset_ff + b_start_ff;
      end else begin
         push_data.done_res = 1'b1;
         push_data.found    = seen_ff;
      end

      count_in   = count_ff;
      seen_in    = seen_ff;
      b_msent_in = b_msent_ff;
      if (push && match_pend) begin
         count_in   = count_ff + WW'(1);
         seen_in    = seen_ff || sel;
         b_msent_in = 1'b1;
      end else if (push) begin
         // end of buffer: drop the stream counts
         count_in = '0;
         seen_in  = 1'b0;
      end
      if (accept) begin
         b_msent_in = 1'b0;
      end

      b_vld_in = b_vld_ff;
      if (accept) begin
         b_vld_in = 1'b1;
      end else if (b_finish) begin
         b_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         b_msent_ff <= 1'b0;
         count_ff   <= '0;
         seen_ff    <= 1'b0;
      end else begin
         b_vld_ff   <= b_vld_in;
         b_msent_ff <= b_msent_in;
         count_ff   <= count_in;
         seen_ff    <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_hit_ff   <= hit_now;
         b_last_ff  <= req_chan.last_byte;
         b_start_ff <= pos_ff - WW'(len_m1);
      end
   end

   wbps_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_chan.valid && rsp_chan.ready),
      .head      (head),
      .stat      (obuf_stat)
   );

   assign rsp_chan.valid         = obuf_stat.not_empty;
   assign rsp_chan.match_start   = head.match_start;
   assign rsp_chan.match_number  = head.match_number;
   assign rsp_chan.is_selected   = head.is_selected;
   assign rsp_chan.match_address = head.match_address;
   assign rsp_chan.done_res      = head.done_res;
   assign rsp_chan.found         = head.found;

endmodule

FILE: design/wbps_checker.sv
// Port-level checks for the scanner and the bind that attaches them.
// Depends on wbps_pkg and on the scanner's top-level ports.
module wbps_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [wbps_pkg::WORD_W-1:0] match_start,
   input logic [wbps_pkg::WORD_W-1:0] match_number,
   input logic                        is_selected,
   input logic [wbps_pkg::WORD_W-1:0] match_address,
   input logic                        done_res,
   input logic                        found
);

   logic [wbps_pkg::WORD_W-1:0] seen_ff;

   // count match items delivered since the last end-of-buffer item
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= done_res ? '0 : seen_ff + wbps_pkg::WORD_W'(1);
      end
   end

   a_number_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> match_number == seen_ff)
      else $error("match number out of sequence");

   a_done_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> match_start == '0 && match_number == '0 &&
                                !is_selected && match_address == '0)
      else $error("end-of-buffer item carries match fields");

   a_match_no_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> !found)
      else $error("match item carries found");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_start) &&
         $stable(match_number) && $stable(match_address) && $stable(done_res))
      else $error("result changed while stalled");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .match_start   (rsp_chan.match_start),
   .match_number  (rsp_chan.match_number),
   .is_selected   (rsp_chan.is_selected),
   .match_address (rsp_chan.match_address),
   .done_res      (rsp_chan.done_res),
   .found         (rsp_chan.found)
);

FILE: tb/wildcard_byte_pattern_scanner_test.sv
`timescale 1ns / 1ps
// Self-checking test of the wildcard byte pattern scanner: directed buffers, back-pressure
// and randomised buffers, each result checked against a local prediction of the scan.
// Depends on wbps_pkg, wbps_req_if, wbps_rsp_if and wildcard_byte_pattern_scanner.
module wildcard_byte_pattern_scanner_test;

   localparam logic [2:0] CSR_UNUSED = 3'd7;   // index beyond the register file
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   wbps_req_if req_chan ();
   wbps_rsp_if rsp_chan ();

   wildcard_byte_pattern_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies, at their reset values
   logic [63:0] cfg_sig_low   = '0;
   logic [63:0] cfg_sig_high  = '0;
   logic [15:0] cfg_wild      = '0;
   logic [4:0]  cfg_sig_len   = 5'd1;
   logic [31:0] cfg_sel_index = '0;
   logic [31:0] cfg_base      = '0;
   logic [31:0] cfg_ofs       = '0;

   // stream state of the scan
   logic [7:0]  window [wbps_pkg::SIG_MAX];
   logic [4:0]  window_fill = '0;
   logic [31:0] byte_pos    = '0;
   logic [31:0] match_count = '0;
   logic        sel_seen    = 1'b0;

   wbps_pkg::rsp_type pending_results [$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_off_left = 0;
   int unsigned sent_count    = 0;
   int unsigned error_count   = 0;
   int unsigned matches_seen  = 0;
   int unsigned buffers_seen  = 0;
   int unsigned found_seen    = 0;
   int unsigned cycle_count   = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      foreach (window[i]) window[i] = '0;
   end

   function automatic void clear_stream();
      foreach (window[i]) window[i] = '0;
      window_fill = '0;
      byte_pos    = '0;
      match_count = '0;
      sel_seen    = 1'b0;
   endfunction

   // Shift one byte into the window and queue the results it causes.
   function automatic void scan_byte(input logic [7:0] value, input logic last);
      wbps_pkg::rsp_type item;
      logic [127:0]      sig_all;
      int unsigned       len;
      int                k;
      logic              hit;
      logic [31:0]       start;
      sig_all = {cfg_sig_high, cfg_sig_low};
      len = (cfg_sig_len > wbps_pkg::SIG_MAX) ? wbps_pkg::SIG_MAX : cfg_sig_len;
      for (k = wbps_pkg::SIG_MAX - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = value;
      if (window_fill < wbps_pkg::SIG_MAX) window_fill++;
      hit = (window_fill >= len);
      for (k = 0; k < len; k++) begin
         if (!cfg_wild[k] && window[len - 1 - k] != sig_all[k * 8 +: 8]) hit = 1'b0;
      end
      if (hit) begin
         start = (len == 0) ? byte_pos : byte_pos - 32'(len - 1);
         item = '0;
         item.match_start   = start;
         item.match_number  = match_count;
         item.is_selected   = (match_count == cfg_sel_index);
         item.match_address = cfg_base + start + cfg_ofs;
         if (item.is_selected) sel_seen = 1'b1;
         match_count++;
         pending_results.insert(pending_results.size(), item);
      end
      byte_pos++;
      if (last) begin
         item = '0;
         item.done_res = 1'b1;
         item.found    = sel_seen;
         pending_results.insert(pending_results.size(), item);
         clear_stream();
      end
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Check results first: no result can leave in the cycle of its own request.
   always @(posedge clock) begin
      wbps_pkg::rsp_type got;
      wbps_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.match_start   = rsp_chan.match_start;
         got.match_number  = rsp_chan.match_number;
         got.is_selected   = rsp_chan.is_selected;
         got.match_address = rsp_chan.match_address;
         got.done_res      = rsp_chan.done_res;
         got.found         = rsp_chan.found;
         if (got.done_res) begin
            buffers_seen++;
            if (got.found) found_seen++;
         end else begin
            matches_seen++;
         end
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual start 0x%0h number 0x%0h",
                     $time, got.match_start, got.match_number);
            $display("%0t:    selected %0b address 0x%0h done %0b found %0b", $time,
                     got.is_selected, got.match_address, got.done_res, got.found);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("match_start", want.match_start, got.match_start);
            check_field("match_number", want.match_number, got.match_number);
            check_field("is_selected", 32'(want.is_selected), 32'(got.is_selected));
            check_field("match_address", want.match_address, got.match_address);
            check_field("done_res", 32'(want.done_res), 32'(got.done_res));
            check_field("found", 32'(want.found), 32'(got.found));
         end
      end
      if (!reset && req_chan.valid && req_chan.ready)
         scan_byte(req_chan.data_byte, req_chan.last_byte);
   end

   // Result side: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= value;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   // Drop the request, wait for every expected result, then let the pipeline settle.
   task automatic wait_quiet();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         wbps_pkg::CSR_SIG_LOW:    cfg_sig_low   = value;
         wbps_pkg::CSR_SIG_HIGH:   cfg_sig_high  = value;
         wbps_pkg::CSR_WILD_MASK:  cfg_wild      = value[15:0];
         wbps_pkg::CSR_SIG_LENGTH: cfg_sig_len   = value[4:0];
         wbps_pkg::CSR_MATCH_IDX:  cfg_sel_index = value[31:0];
         wbps_pkg::CSR_BASE_ADDR:  cfg_base      = value[31:0];
         wbps_pkg::CSR_ADDR_OFS:   cfg_ofs       = value[31:0];
         default: ;
      endcase
   endtask

   task automatic csr_idle();
      csr_we <= 1'b0;
   endtask

   // Reset values: one-byte signature of zero, first match selected.
   task automatic test_reset_values();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_quiet();
   endtask

   // Empty signature matches at every offset; the address sum wraps.
   task automatic test_empty_signature();
      write_reg(wbps_pkg::CSR_SIG_LENGTH, 64'd0);
      write_reg(wbps_pkg::CSR_MATCH_IDX, 64'd1);
      write_reg(wbps_pkg::CSR_BASE_ADDR, 64'hFFFF_FFFF);
      write_reg(wbps_pkg::CSR_ADDR_OFS, 64'd1);
      csr_idle();
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      wait_quiet();
   endtask

   // Oversized length saturates to the full window; the match lands with the last byte.
   task automatic test_full_window();
      logic [127:0] sig_all;
      logic [7:0]   value;
      write_reg(wbps_pkg::CSR_SIG_LOW, 64'h00FF_A55A_0FF0_FF00);
      write_reg(wbps_pkg::CSR_SIG_HIGH, 64'h8001_7FFE_C33C_00FF);
      write_reg(wbps_pkg::CSR_WILD_MASK, 64'h8421);
      write_reg(wbps_pkg::CSR_SIG_LENGTH, 64'd31);
      write_reg(wbps_pkg::CSR_MATCH_IDX, 64'd0);
      write_reg(wbps_pkg::CSR_BASE_ADDR, 64'h8000_0000);
      write_reg(wbps_pkg::CSR_ADDR_OFS, 64'h7FFF_FFFF);
      write_reg(CSR_UNUSED, '1);
      csr_idle();
      sig_all = {cfg_sig_high, cfg_sig_low};
      for (int j = 0; j < wbps_pkg::SIG_MAX; j++) begin
         value = sig_all[j * 8 +: 8];
         send_byte(cfg_wild[j] ? ~value : value, j == wbps_pkg::SIG_MAX - 1);
      end
      wait_quiet();
   endtask

   // Change the signature between two bytes of one buffer; the window is kept.
   task automatic test_midbuffer_write();
      write_reg(wbps_pkg::CSR_SIG_LOW, 64'hCDAB);
      write_reg(wbps_pkg::CSR_WILD_MASK, 64'h0);
      write_reg(wbps_pkg::CSR_SIG_LENGTH, 64'd2);
      write_reg(wbps_pkg::CSR_MATCH_IDX, 64'hFFFF_FFFF);
      csr_idle();
      send_byte(8'hAB, 1'b0);
      wait_quiet();
      write_reg(wbps_pkg::CSR_SIG_LOW, 64'h11AB);
      csr_idle();
      send_byte(8'h11, 1'b1);
      wait_quiet();
   endtask

   // Hold the result side off so the queue fills and the request side stalls.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      write_reg(wbps_pkg::CSR_SIG_LENGTH, 64'd0);
      write_reg(wbps_pkg::CSR_MATCH_IDX, 64'd5);
      csr_idle();
      hold_off_left = 80;
      for (int i = 0; i < 30; i++) send_byte(8'($urandom), i == 29);
      wait_quiet();
   endtask

   task automatic test_random_buffers(input int unsigned idle_pct, input int unsigned stall,
                                      input int unsigned goal);
      int unsigned  first_sent;
      int unsigned  len;
      int unsigned  eff;
      int unsigned  n;
      int unsigned  at;
      logic [7:0]   alphabet [4];
      logic [7:0]   stream [64];
      logic [127:0] sig_all;
      logic [15:0]  mask;
      logic [31:0]  sel;
      bit           noise;
      bit           broken;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      first_sent    = sent_count;
      while (sent_count - first_sent < goal) begin
         foreach (alphabet[i]) alphabet[i] = 8'($urandom);
         for (int i = 0; i < wbps_pkg::SIG_MAX; i++)
            sig_all[i * 8 +: 8] = ($urandom_range(7) == 0) ? 8'($urandom)
                                                           : alphabet[$urandom_range(3)];
         case ($urandom_range(15))
            0:       len = $urandom_range(17, 31);
            1, 2:    len = $urandom_range(7, 16);
            default: len = $urandom_range(0, 6);
         endcase
         case ($urandom_range(7))
            0:       mask = '0;
            1:       mask = '1;
            default: mask = 16'($urandom & $urandom);
         endcase
         sel = ($urandom_range(7) == 0) ? 32'($urandom) : 32'($urandom_range(3));
         eff = (len > wbps_pkg::SIG_MAX) ? wbps_pkg::SIG_MAX : len;
         // upper bits of the narrow registers carry junk that must be dropped
         write_reg(wbps_pkg::CSR_SIG_LOW, sig_all[63:0]);
         write_reg(wbps_pkg::CSR_SIG_HIGH, sig_all[127:64]);
         write_reg(wbps_pkg::CSR_WILD_MASK, {32'($urandom), 16'($urandom), mask});
         write_reg(wbps_pkg::CSR_SIG_LENGTH, {32'($urandom), 27'($urandom), 5'(len)});
         write_reg(wbps_pkg::CSR_MATCH_IDX, {32'($urandom), sel});
         write_reg(wbps_pkg::CSR_BASE_ADDR, {32'($urandom), 32'($urandom)});
         write_reg(wbps_pkg::CSR_ADDR_OFS, {32'($urandom), 32'($urandom)});
         if ($urandom_range(7) == 0) write_reg(CSR_UNUSED, {32'($urandom), 32'($urandom)});
         csr_idle();

         noise  = ($urandom_range(7) == 0);
         broken = ($urandom_range(9) == 0);
         n = $urandom_range(1, eff + 20);
         for (int i = 0; i < n; i++)
            stream[i] = noise ? 8'($urandom) : alphabet[$urandom_range(3)];
         // plant whole signature copies, wildcard positions filled at random
         if (!noise && eff <= n) begin
            repeat ($urandom_range(1, 3)) begin
               at = $urandom_range(0, n - eff);
               for (int j = 0; j < eff; j++)
                  stream[at + j] = mask[j] ? 8'($urandom) : sig_all[j * 8 +: 8];
            end
         end
         for (int i = 0; i < n; i++) send_byte(stream[i], !broken && i == n - 1);
         wait_quiet();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= '0;
      req_chan.last_byte <= 1'b0;
      csr_we         <= 1'b0;
      csr_index      <= wbps_pkg::CSR_SIG_LOW;
      csr_wdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_empty_signature();
      test_full_window();
      test_midbuffer_write();
      test_backpressure();
      test_random_buffers(0, 0, 275);
      test_random_buffers(84, 0, 275);
      test_random_buffers(0, 84, 275);
      test_random_buffers(36, 36, 275);
      wait_quiet();

      $display("Scanned %0d bytes: %0d matches, %0d buffers closed (%0d with the pick found)",
               sent_count, matches_seen, buffers_seen, found_seen);
      $display("Covered empty, short and saturated signatures, wildcards and back-pressure");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/wbps_pkg.sv
design/wbps_req_if.sv
design/wbps_rsp_if.sv
design/wbps_cell.sv
design/wbps_obuf.sv
design/wildcard_byte_pattern_scanner.sv
design/wbps_checker.sv
tb/wildcard_byte_pattern_scanner_test.sv
